FILE: design/spvm_pkg.sv
// ----------------------------------------------------------------------------
// spvm_pkg
// Shared widths, types and constant tables of the polyphonic sine voice mixer.
// ----------------------------------------------------------------------------
package spvm_pkg;

  localparam int VOICES          = 13;
  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;

  localparam int GATE_W     = 13;
  localparam int ENV_W      = 17;
  localparam int REF_W      = 31;
  localparam int GAIN_W     = 15;
  localparam int SAMPLE_W   = 16;
  localparam int RATIO_W    = 17;
  localparam int SHIFT_W    = 3;
  localparam int PROD_W     = REF_W + RATIO_W;
  localparam int SINE_W     = 16;
  localparam int QUARTER_W  = 15;
  localparam int SG_W       = SINE_W + GAIN_W + 1;
  localparam int TERM_W     = 48;
  localparam int VIDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ACC_W      = TERM_W + VIDX_W;
  localparam int MIX_SHIFT  = 31;
  localparam int INC_SHIFT  = 17;

  localparam int QIDX_W = SINE_TABLE_BITS - 2;
  localparam int QSIZE  = 1 << QIDX_W;

  localparam int SEMITONES    = 12;
  localparam int VOICE_OFFSET = 3;

  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(65536);

  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_REF_INC  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ENV_STEP = 2'd2;

  localparam logic [REF_W-1:0]  REF_INC_RESET  = REF_W'(42852282);
  localparam logic [GAIN_W-1:0] GAIN_RESET     = GAIN_W'(4096);
  localparam logic [ENV_W-1:0]  ENV_STEP_RESET = ENV_W'(1638);

  typedef struct packed {
    logic [REF_W-1:0]  ref_inc;
    logic [GAIN_W-1:0] gain;
    logic [ENV_W-1:0]  env_step;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [ENV_W-1:0]      env;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [VIDX_W-1:0] idx;
    logic              held;
    logic              first;
    logic              last;
  } issue_t;

  localparam logic [0:SEMITONES-1][RATIO_W-1:0] SEMITONE_Q16 = '{
    17'd65536, 17'd69433, 17'd73562, 17'd77935, 17'd82570, 17'd87480,
    17'd92682, 17'd98193, 17'd104031, 17'd110217, 17'd116771, 17'd123715
  };

  // Fifth-order quarter-wave polynomial, Q16 in, Q15 out, clamped.
  function automatic logic [QUARTER_W-1:0] quarter_sine(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    x2 = (x * x) >> 16;
    t  = (64'd5223 * x2) >> 16;
    t  = 64'd42334 - t;
    t  = (t * x2) >> 16;
    t  = 64'd102944 - t;
    y  = ((t * x) >> 16) >> 1;
    if (y > 64'd32767) begin
      y = 64'd32767;
    end
    return QUARTER_W'(y);
  endfunction

  function automatic logic [QSIZE-1:0][QUARTER_W-1:0] build_quarter();
    logic [QSIZE-1:0][QUARTER_W-1:0] tab;
    for (int r = 0; r < QSIZE; r++) begin
      tab[r] = quarter_sine(longint'(r) << (16 - QIDX_W));
    end
    return tab;
  endfunction

  function automatic logic [VOICES-1:0][RATIO_W-1:0] build_ratio();
    logic [VOICES-1:0][RATIO_W-1:0] tab;
    for (int v = 0; v < VOICES; v++) begin
      tab[v] = SEMITONE_Q16[(v + VOICE_OFFSET) % SEMITONES];
    end
    return tab;
  endfunction

  function automatic logic [VOICES-1:0][SHIFT_W-1:0] build_shift();
    logic [VOICES-1:0][SHIFT_W-1:0] tab;
    for (int v = 0; v < VOICES; v++) begin
      tab[v] = SHIFT_W'((v + VOICE_OFFSET) / SEMITONES);
    end
    return tab;
  endfunction

  localparam logic [QSIZE-1:0][QUARTER_W-1:0] QUARTER_TAB = build_quarter();
  localparam logic [QUARTER_W-1:0] QUARTER_TOP = quarter_sine(64'd65536);
  localparam logic [VOICES-1:0][RATIO_W-1:0] VOICE_RATIO = build_ratio();
  localparam logic [VOICES-1:0][SHIFT_W-1:0] VOICE_SHIFT = build_shift();

endpackage

FILE: design/spvm_cfg.sv
// ----------------------------------------------------------------------------
// spvm_cfg
// Register file behind the APB port: reference increment, gain, envelope step.
// ----------------------------------------------------------------------------
module spvm_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spvm_pkg::ADDR_W-1:0] paddr,
  input  logic [spvm_pkg::DATA_W-1:0] pwdata,
  output logic [spvm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output spvm_pkg::cfg_t              cfg
);
  import spvm_pkg::*;

  logic                 wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_inc  <= REF_INC_RESET;
      cfg.gain     <= GAIN_RESET;
      cfg.env_step <= ENV_STEP_RESET;
    end else if (wr) begin
      case (reg_idx)
        REG_REF_INC:  cfg.ref_inc  <= pwdata[REF_W-1:0];
        REG_GAIN:     cfg.gain     <= pwdata[GAIN_W-1:0];
        REG_ENV_STEP: cfg.env_step <= pwdata[ENV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REF_INC:  prdata = DATA_W'(cfg.ref_inc);
      REG_GAIN:     prdata = DATA_W'(cfg.gain);
      REG_ENV_STEP: prdata = DATA_W'(cfg.env_step);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: design/spvm_state_ram.sv
// ----------------------------------------------------------------------------
// spvm_state_ram
// Voice state memory holding phase and envelope, one read and one write port.
// ----------------------------------------------------------------------------
module spvm_state_ram (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [spvm_pkg::VIDX_W-1:0] rd_addr,
  output spvm_pkg::entry_t            rd_data,
  input  logic                        wr_en,
  input  logic [spvm_pkg::VIDX_W-1:0] wr_addr,
  input  spvm_pkg::entry_t            wr_data
);
  import spvm_pkg::*;

  entry_t              mem [VOICES];
  logic [VOICES-1:0]   entry_valid;
  entry_t              rd_q;
  logic                rd_valid_q;

  // An entry that was never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q       <= mem[rd_addr];
      rd_valid_q <= entry_valid[rd_addr];
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

FILE: design/spvm_voice_dp.sv
// ----------------------------------------------------------------------------
// spvm_voice_dp
// Per-voice pipeline: envelope and phase update, sine lookup, gain and
// envelope products, and the mix accumulator.
// ----------------------------------------------------------------------------
module spvm_voice_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  spvm_pkg::cfg_t              cfg,
  input  spvm_pkg::issue_t            issue,
  input  spvm_pkg::entry_t            rd_data,
  output logic                        wr_en,
  output logic [spvm_pkg::VIDX_W-1:0] wr_addr,
  output spvm_pkg::entry_t            wr_data,
  output logic signed [spvm_pkg::ACC_W-1:0] acc,
  output logic                        sum_done
);
  import spvm_pkg::*;

  issue_t s1;
  issue_t s2;
  issue_t s3;
  issue_t s4;

  logic [ENV_W-1:0]           env_new;
  logic [ENV_W:0]             env_sum;
  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [1:0]                 quad;
  logic [QIDX_W-1:0]          qr;
  logic [QIDX_W-1:0]          qpos;
  logic [QUARTER_W-1:0]       mag;
  logic signed [SINE_W-1:0]   sine;

  logic [PHASE_BITS-1:0]    s2_phase;
  logic [ENV_W-1:0]         s2_env;
  logic [PROD_W-1:0]        s2_prod;
  logic [SHIFT_W-1:0]       s2_shift;
  logic signed [SINE_W-1:0] s2_sine;
  logic [63:0]              inc_wide;

  logic signed [SG_W-1:0]   s3_sg;
  logic [ENV_W-1:0]         s3_env;
  logic signed [SG_W+ENV_W:0] term_full;
  logic signed [TERM_W-1:0] s4_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
      sum_done <= 1'b0;
    end else begin
      s1.valid <= issue.valid;
      s2.valid <= s1.valid;
      s3.valid <= s2.valid;
      s4.valid <= s3.valid;
      sum_done <= s4.valid && s4.last;
    end
    s1.idx   <= issue.idx;
    s1.held  <= issue.held;
    s1.first <= issue.first;
    s1.last  <= issue.last;
    {s2.idx, s2.held, s2.first, s2.last} <= {s1.idx, s1.held, s1.first, s1.last};
    {s3.idx, s3.held, s3.first, s3.last} <= {s2.idx, s2.held, s2.first, s2.last};
    {s4.idx, s4.held, s4.first, s4.last} <= {s3.idx, s3.held, s3.first, s3.last};
  end

  always_comb begin
    env_sum = {1'b0, rd_data.env} + {1'b0, cfg.env_step};
    if (s1.held) begin
      if (rd_data.env < ENV_ONE) begin
        env_new = (env_sum > {1'b0, ENV_ONE}) ? ENV_ONE : env_sum[ENV_W-1:0];
      end else begin
        env_new = rd_data.env;
      end
    end else begin
      env_new = (rd_data.env < cfg.env_step) ? '0 : rd_data.env - cfg.env_step;
    end
  end

  always_comb begin
    tab_idx = rd_data.phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    quad    = tab_idx[SINE_TABLE_BITS-1 -: 2];
    qr      = tab_idx[QIDX_W-1:0];
    qpos    = quad[0] ? QIDX_W'(-qr) : qr;
    mag     = (quad[0] && qr == '0) ? QUARTER_TOP : QUARTER_TAB[qpos];
    sine    = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    s2_phase <= rd_data.phase;
    s2_env   <= env_new;
    s2_prod  <= PROD_W'(cfg.ref_inc) * PROD_W'(VOICE_RATIO[s1.idx]);
    s2_shift <= VOICE_SHIFT[s1.idx];
    s2_sine  <= sine;
  end

  assign inc_wide      = 64'(s2_prod) << s2_shift;
  assign wr_en         = s2.valid;
  assign wr_addr       = s2.idx;
  assign wr_data.phase = s2_phase + inc_wide[INC_SHIFT +: PHASE_BITS];
  assign wr_data.env   = s2_env;

  always_ff @(posedge clk) begin
    s3_sg  <= SG_W'(s2_sine) * $signed({1'b0, cfg.gain});
    s3_env <= s2_env;
  end

  assign term_full = (SG_W+ENV_W+1)'(s3_sg) * $signed({1'b0, s3_env});

  always_ff @(posedge clk) begin
    s4_term <= term_full[TERM_W-1:0];
    if (s4.valid) begin
      acc <= s4.first ? ACC_W'(s4_term) : acc + ACC_W'(s4_term);
    end
  end

endmodule

FILE: design/polyphonic_sine_voice_mixer.sv
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_mixer
// Thirteen sine voices with linear envelopes mixed into one 16-bit sample.
// A new gate beat is taken only once the previous sample is loaded into the
// output register, which an output stall can hold off; one voice is read from
// the voice memory per cycle, then the result passes the four pipeline
// stages, the mix done flag and the output register.
// Reset clears the voice memory valid bits, so every phase and envelope reads
// as zero at once; registers return to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module polyphonic_sine_voice_mixer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spvm_pkg::GATE_W-1:0]   gate_mask,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [spvm_pkg::SAMPLE_W-1:0] sample,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spvm_pkg::ADDR_W-1:0]   paddr,
  input  logic [spvm_pkg::DATA_W-1:0]   pwdata,
  output logic [spvm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import spvm_pkg::*;

  localparam int Q_W = ACC_W - MIX_SHIFT;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'((64'd1 << MIX_SHIFT) - 64'd1);
  localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(32767);
  localparam logic signed [Q_W-1:0] SAT_LO = -Q_W'(32768);

  cfg_t   cfg;
  issue_t issue;
  entry_t rd_data;
  entry_t wr_data;
  logic   wr_en;
  logic [VIDX_W-1:0] wr_addr;
  logic signed [ACC_W-1:0] acc;
  logic   sum_done;

  logic              busy;
  logic              issuing;
  logic [VIDX_W-1:0] issue_idx;
  logic [GATE_W-1:0] gates;
  logic [VOICES-1:0] held_vec;
  logic              pend;
  logic              accept;
  logic              load;

  logic signed [ACC_W-1:0]    biased;
  logic signed [Q_W-1:0]      quot;
  logic signed [SAMPLE_W-1:0] sat;

  spvm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spvm_state_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (issuing),
    .rd_addr (issue_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  spvm_voice_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .issue    (issue),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .acc      (acc),
    .sum_done (sum_done)
  );

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign load     = pend && (!out_valid || !out_stall);

  always_comb begin
    for (int v = 0; v < VOICES; v++) begin
      held_vec[v] = (v < GATE_W) ? gates[v % GATE_W] : 1'b0;
    end
  end

  assign issue.valid = issuing;
  assign issue.idx   = issue_idx;
  assign issue.held  = held_vec[issue_idx];
  assign issue.first = (issue_idx == '0);
  assign issue.last  = (issue_idx == VIDX_W'(VOICES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      issuing   <= 1'b0;
      issue_idx <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy      <= 1'b1;
        issuing   <= 1'b1;
        issue_idx <= '0;
      end else if (issuing) begin
        if (issue.last) begin
          issuing <= 1'b0;
        end else begin
          issue_idx <= issue_idx + 1'b1;
        end
      end
      if (sum_done) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
        busy <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gates <= gate_mask;
    end
    if (load) begin
      sample <= sat;
    end
  end

  // The mix is scaled down with truncation toward zero, then saturated.
  always_comb begin
    biased = (acc < 0) ? acc + ROUND_BIAS : acc;
    quot   = Q_W'(biased >>> MIX_SHIFT);
    if (quot > SAT_HI) begin
      sat = SAMPLE_W'(SAT_HI);
    end else if (quot < SAT_LO) begin
      sat = SAMPLE_W'(SAT_LO);
    end else begin
      sat = quot[SAMPLE_W-1:0];
    end
  end

`ifndef SYNTH
  a_accept_starts_issue: assert property (@(posedge clk) disable iff (rst)
    accept |=> (issuing && issue_idx == '0))
    else $error("accepted beat did not start the voice sweep");

  a_issue_only_busy: assert property (@(posedge clk) disable iff (rst)
    issuing |-> busy)
    else $error("voice sweep running while idle");

  a_done_after_sweep: assert property (@(posedge clk) disable iff (rst)
    sum_done |-> (busy && !issuing && !pend))
    else $error("mix finished outside its sweep");

  a_pend_no_issue: assert property (@(posedge clk) disable iff (rst)
    pend |-> (!issuing && busy))
    else $error("result pending while a sweep runs");
`endif

endmodule

FILE: bench/polyphonic_sine_voice_mixer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_mixer_checker
// Follows the register port and both beat channels of the voice mixer. It
// keeps its own voice phases, envelopes and register copies, works out the
// mixed sample of every accepted gate beat, and compares each sample beat and
// each register read against what it holds.
// ----------------------------------------------------------------------------
module polyphonic_sine_voice_mixer_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [spvm_pkg::GATE_W-1:0]          gate_mask,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [spvm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [spvm_pkg::ADDR_W-1:0]          paddr,
  input  logic [spvm_pkg::DATA_W-1:0]          pwdata,
  input  logic [spvm_pkg::DATA_W-1:0]          prdata,
  input  logic                                 pready,
  output int                                   errors,
  output int                                   outstanding
);
  import spvm_pkg::*;

  localparam logic [SEMITONES-1:0][RATIO_W-1:0] SEMI_RATIO = {
    17'd123715, 17'd116771, 17'd110217, 17'd104031, 17'd98193, 17'd92682,
    17'd87480, 17'd82570, 17'd77935, 17'd73562, 17'd69433, 17'd65536
  };
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  logic [REF_W-1:0]            ref_inc;
  logic [GAIN_W-1:0]           gain;
  logic [ENV_W-1:0]            env_step;
  logic [PHASE_BITS-1:0]       osc_phase [VOICES];
  logic [ENV_W-1:0]            env_level [VOICES];
  logic signed [SAMPLE_W-1:0]  pending_samples [$];
  logic signed [SAMPLE_W-1:0]  want_sample;
  logic [DATA_W-1:0]           want_reg;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  function automatic logic [PHASE_BITS-1:0] voice_step(input int v);
    longint unsigned p;
    p = ref_inc;
    p = p * SEMI_RATIO[(v + VOICE_OFFSET) % SEMITONES];
    p = (p << ((v + VOICE_OFFSET) / SEMITONES)) >> INC_SHIFT;
    return p[PHASE_BITS-1:0];
  endfunction

  function automatic longint wave_at(input logic [PHASE_BITS-1:0] ph);
    logic [SINE_TABLE_BITS-1:0] idx;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    idx = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
    x = idx[QIDX_W-1:0];
    if (idx[QIDX_W]) begin
      x = QSIZE - x;
    end
    x = x << (16 - QIDX_W);
    x2 = (x * x) >> 16;
    t = 42334 - ((5223 * x2) >> 16);
    t = 102944 - ((t * x2) >> 16);
    y = ((t * x) >> 16) >> 1;
    if (y > SAMPLE_MAX) begin
      y = SAMPLE_MAX;
    end
    return idx[SINE_TABLE_BITS-1] ? -longint'(y) : longint'(y);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] mix_sample(
    input logic [GATE_W-1:0] gates
  );
    longint acc;
    longint lvl;
    longint res;
    acc = 0;
    for (int v = 0; v < VOICES; v++) begin
      lvl = env_level[v];
      if (v < GATE_W && gates[v]) begin
        if (lvl < longint'(ENV_ONE)) begin
          lvl = lvl + longint'(env_step);
          if (lvl > longint'(ENV_ONE)) begin
            lvl = ENV_ONE;
          end
        end
      end else begin
        lvl = (lvl < longint'(env_step)) ? 0 : lvl - longint'(env_step);
      end
      env_level[v] = lvl[ENV_W-1:0];
      acc = acc + wave_at(osc_phase[v]) * longint'(gain) * lvl;
      osc_phase[v] = osc_phase[v] + voice_step(v);
    end
    res = (acc < 0) ? -((-acc) >>> MIX_SHIFT) : (acc >>> MIX_SHIFT);
    if (res > SAMPLE_MAX) begin
      res = SAMPLE_MAX;
    end
    if (res < SAMPLE_MIN) begin
      res = SAMPLE_MIN;
    end
    return res[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ref_inc = REF_INC_RESET;
      gain = GAIN_RESET;
      env_step = ENV_STEP_RESET;
      for (int v = 0; v < VOICES; v++) begin
        osc_phase[v] = '0;
        env_level[v] = '0;
      end
      pending_samples.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_REF_INC:  ref_inc = pwdata[REF_W-1:0];
            REG_GAIN:     gain = pwdata[GAIN_W-1:0];
            REG_ENV_STEP: env_step = pwdata[ENV_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[ADDR_W-1:2])
            REG_REF_INC:  want_reg = DATA_W'(ref_inc);
            REG_GAIN:     want_reg = DATA_W'(gain);
            REG_ENV_STEP: want_reg = DATA_W'(env_step);
            default:      want_reg = prdata;
          endcase
          if (prdata !== want_reg) begin
            errors = errors + 1;
            $display("%0t: register %0d read mismatch, expected %0d, got %0d",
                     $time, paddr[ADDR_W-1:2], want_reg, prdata);
          end
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_samples.size() == 0) begin
          errors = errors + 1;
          $display("%0t: sample beat with nothing expected, expected none, got %0d",
                   $time, sample);
        end else begin
          want_sample = pending_samples.pop_front();
          if (sample !== want_sample) begin
            errors = errors + 1;
            $display("%0t: sample mismatch, expected %0d, got %0d",
                     $time, want_sample, sample);
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_samples.push_back(mix_sample(gate_mask));
      end
    end
    outstanding = pending_samples.size();
  end

endmodule

FILE: bench/polyphonic_sine_voice_mixer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_mixer_tb
// Drives gate beats and register writes into the voice mixer: a short
// directed run at full gain and full envelope step, then phases of held and
// released key patterns under extreme and random settings, with random gaps
// and stalls on both channels. The checker beside the block decides each beat.
// ----------------------------------------------------------------------------
module polyphonic_sine_voice_mixer_tb;
  import spvm_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [GATE_W-1:0]           gate_mask = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]  sample;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ADDR_W-1:0]           paddr = '0;
  logic [DATA_W-1:0]           pwdata = '0;
  logic [DATA_W-1:0]           prdata;
  logic                        pready;
  int                          errors;
  int                          outstanding;
  int                          send_pct = 0;
  int                          stall_pct = 0;
  int                          cycles = 0;
  int                          phase;

  polyphonic_sine_voice_mixer dut (.*);

  polyphonic_sine_voice_mixer_checker checker_i (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_gate(input logic [GATE_W-1:0] m);
    if ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_pct) begin
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    gate_mask <= m;
    @(negedge clk);
    while (in_stall) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) begin
      @(negedge clk);
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [DATA_W-1:0] ref_val,
                              input logic [DATA_W-1:0] gain_val,
                              input logic [DATA_W-1:0] step_val);
    apb_access(1'b1, REG_REF_INC, ref_val);
    apb_access(1'b1, REG_GAIN, gain_val);
    apb_access(1'b1, REG_ENV_STEP, step_val);
    apb_access(1'b0, REG_REF_INC, '0);
    apb_access(1'b0, REG_GAIN, '0);
    apb_access(1'b0, REG_ENV_STEP, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // Keys are mostly held in runs of random length, with
  // an occasional unrelated beat mixed in.
  task automatic play_gates(input int count);
    logic [GATE_W-1:0] keys;
    int run;
    keys = GATE_W'($urandom);
    run = 0;
    repeat (count) begin
      if (run == 0) begin
        run = $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0: keys = GATE_W'($urandom);
          1: keys = keys ^ (GATE_W'(1) << $urandom_range(0, GATE_W - 1));
          2: keys = '0;
          default: keys = '1;
        endcase
      end
      run = run - 1;
      send_gate(($urandom_range(0, 9) == 0) ? GATE_W'($urandom) : keys);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    program_regs(32'h2000_0000, 32'h7FFF, 32'h1_0000);
    send_gate('0);
    repeat (4) send_gate('1);
    send_gate('0);
    send_gate(13'h1555);
    send_gate(13'h0AAA);
    for (int v = 0; v < GATE_W; v++) begin
      send_gate(GATE_W'(1) << v);
    end
    send_gate('1);
    send_gate('0);
    drain();
    for (phase = 1; phase <= 9; phase++) begin
      case (phase % 4)
        1: begin
          send_pct = 77;
          stall_pct = 0;
        end
        2: begin
          send_pct = 0;
          stall_pct = 77;
        end
        3: begin
          send_pct = 17;
          stall_pct = 17;
        end
        default: begin
          send_pct = 0;
          stall_pct = 0;
        end
      endcase
      case (phase)
        2: program_regs(32'h7FFF_FFFF, 32'h7FFF, 32'h0);
        3: program_regs(32'h0, 32'h7FFF, 32'h1_0000);
        4: program_regs(32'h1, 32'h0, 32'h1);
        5: begin
          program_regs('1, '1, '1);
          apb_access(1'b1, REG_SPARE, $urandom);
        end
        7: program_regs($urandom, $urandom_range(0, 32767), $urandom_range(0, 131071));
        default: program_regs($urandom, $urandom_range(0, 32767),
                              $urandom_range(1, 20000));
      endcase
      play_gates(50);
      drain();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
